// ===== sv/sfr_pkg.sv =====
`default_nettype none

package sfr_pkg;

   localparam int unsigned ByteWidth  = 8;
   localparam int unsigned CountWidth = 16;
   localparam int unsigned RspWidth   = ByteWidth + 2 * CountWidth;

   localparam logic [ByteWidth-1:0]  EscByte       = 8'hFF;
   localparam logic [ByteWidth-1:0]  ZeroCode      = 8'hF0;
   localparam logic [CountWidth-1:0] FrameOverhead = 16'd6;

   // Fields from the lowest bit up: data byte, byte index, frame total.
   typedef struct packed {
      logic [CountWidth-1:0] frame_total;
      logic [CountWidth-1:0] byte_index;
      logic [ByteWidth-1:0]  data_byte;
   } rsp_data_type;

   typedef struct packed {
      rsp_data_type data;
      logic         last;
   } rsp_item_type;

endpackage

`default_nettype wire

// ===== sv/stuffed_frame_receiver.sv =====
// Channel  Ports                          Contents
// req      req_tvalid/tready/tdata/tuser  stuffed byte; frame start flag in tuser
// rsp      rsp_tvalid/tready/tdata/tlast  decoded byte, index, total; tlast ends frame
// csr      csr_valid/ready/data           expected payload length
//
// An item is decoded in the cycle it is accepted, and its result is registered in the
// output register, or in the skid register while that is stalled; while req_tready is
// high, one item can be accepted every cycle. The skid register keeps the input open
// while one result waits; a second waiting result closes req_tready.
// Reset is synchronous and clears the frame state, the length register and both
// output stages. A new length value takes effect at the next frame start.
`default_nettype none

module stuffed_frame_receiver
   import sfr_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_tvalid,
   output logic                       req_tready,
   input  wire logic [ByteWidth-1:0]  req_tdata,   // in_byte
   input  wire logic                  req_tuser,   // frame_start
   output logic                       rsp_tvalid,
   input  wire logic                  rsp_tready,
   output logic [RspWidth-1:0]        rsp_tdata,   // data_byte, byte_index, frame_total
   output logic                       rsp_tlast,   // frame_last
   input  wire logic                  csr_valid,
   output logic                       csr_ready,
   input  wire logic [CountWidth-1:0] csr_data     // expected_payload_length
);

   logic [CountWidth-1:0] exp_len_ff, exp_len_in;
   logic                  esc_ff, esc_in;
   logic [CountWidth-1:0] count_ff, count_in;
   logic [CountWidth-1:0] total_ff, total_in;
   logic [ByteWidth-1:0]  hdr_ff, hdr_in;
   logic                  done_ff, done_in;
   logic                  main_valid_ff, main_valid_in;
   rsp_item_type          main_ff, main_in;
   logic                  skid_valid_ff, skid_valid_in;
   rsp_item_type          skid_ff, skid_in;

   logic                  accept;
   logic                  have;
   logic                  produce;
   logic                  take;
   logic [ByteWidth-1:0]  dec;
   logic [CountWidth:0]   cfg_sum;
   logic [CountWidth-1:0] cfg_total;
   logic                  esc_c;
   logic [CountWidth-1:0] count_c;
   logic [CountWidth-1:0] total_c;
   logic [ByteWidth-1:0]  hdr_c;
   logic                  done_c;
   logic                  last;
   rsp_item_type          new_item;

   assign csr_ready  = 1'b1;
   assign req_tready = !skid_valid_ff;
   assign accept     = req_tvalid && req_tready;
   assign take       = main_valid_ff && rsp_tready;

   assign exp_len_in = (csr_valid && csr_ready) ? csr_data : exp_len_ff;

   always_comb begin
      cfg_sum = {1'b0, exp_len_ff} + {1'b0, FrameOverhead};
      if (exp_len_ff == '0) begin
         cfg_total = '0;
      end else if (cfg_sum[CountWidth]) begin
         cfg_total = '1;
      end else begin
         cfg_total = cfg_sum[CountWidth-1:0];
      end
   end

   always_comb begin
      if (req_tuser) begin
         esc_c   = 1'b0;
         count_c = '0;
         total_c = cfg_total;
         hdr_c   = '0;
         done_c  = 1'b0;
      end else begin
         esc_c   = esc_ff;
         count_c = count_ff;
         total_c = total_ff;
         hdr_c   = hdr_ff;
         done_c  = done_ff;
      end

      esc_in   = esc_c;
      count_in = count_c;
      total_in = total_c;
      hdr_in   = hdr_c;
      done_in  = done_c;
      have     = 1'b0;
      dec      = req_tdata;
      last     = 1'b0;

      if (!done_c) begin
         if (esc_c) begin
            esc_in = 1'b0;
            if (req_tdata == EscByte) begin
               dec  = EscByte;
               have = 1'b1;
            end else if (req_tdata == ZeroCode) begin
               dec  = '0;
               have = 1'b1;
            end
         end else if (req_tdata == EscByte) begin
            esc_in = 1'b1;
         end else begin
            have = 1'b1;
         end

         if (have) begin
            count_in = count_c + 1'b1;
            if (total_c == '0) begin
               if (count_c == '0) begin
                  hdr_in = dec;
               end else if (count_c == CountWidth'(1)) begin
                  total_in = {dec, hdr_c};
                  if (total_in <= CountWidth'(2)) begin
                     last = 1'b1;
                  end
               end
            end
            if (total_in != '0 && count_in >= total_in) begin
               last = 1'b1;
            end
            if (last) begin
               done_in = 1'b1;
            end
         end
      end
   end

   assign produce = accept && have;

   always_comb begin
      new_item.data.data_byte   = dec;
      new_item.data.byte_index  = count_c;
      new_item.data.frame_total = total_in;
      new_item.last             = last;
   end

   always_comb begin
      main_valid_in = main_valid_ff;
      main_in       = main_ff;
      skid_valid_in = skid_valid_ff;
      skid_in       = skid_ff;
      if (!main_valid_ff || take) begin
         if (skid_valid_ff) begin
            main_valid_in = 1'b1;
            main_in       = skid_ff;
            skid_valid_in = 1'b0;
         end else begin
            main_valid_in = produce;
            main_in       = new_item;
         end
      end else if (produce) begin
         skid_valid_in = 1'b1;
         skid_in       = new_item;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         exp_len_ff    <= '0;
         esc_ff        <= 1'b0;
         count_ff      <= '0;
         total_ff      <= '0;
         hdr_ff        <= '0;
         done_ff       <= 1'b0;
         main_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         exp_len_ff    <= exp_len_in;
         main_valid_ff <= main_valid_in;
         skid_valid_ff <= skid_valid_in;
         if (accept) begin
            esc_ff   <= esc_in;
            count_ff <= count_in;
            total_ff <= total_in;
            hdr_ff   <= hdr_in;
            done_ff  <= done_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      main_ff <= main_in;
      skid_ff <= skid_in;
   end

   assign rsp_tvalid = main_valid_ff;
   assign rsp_tdata  = main_ff.data;
   assign rsp_tlast  = main_ff.last;

endmodule

`default_nettype wire

// ===== sv/sfr_checker.sv =====
`default_nettype none

module sfr_checker
   import sfr_pkg::*;
(
   input wire logic                  clock,
   input wire logic                  reset,
   input wire logic                  req_tready,
   input wire logic                  rsp_tvalid,
   input wire logic                  rsp_tready,
   input wire logic [RspWidth-1:0]   rsp_tdata,
   input wire logic                  rsp_tlast
);

   rsp_data_type          rsp;
   logic [CountWidth:0]   next_index;

   assign rsp        = rsp_tdata;
   assign next_index = {1'b0, rsp.byte_index} + 1'b1;

   // A stalled result keeps its contents.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast))
      else $error("result changed while stalled");

   // Reset empties both output stages and opens the input.
   a_reset_clear: assert property (@(posedge clock)
      reset |=> !rsp_tvalid && req_tready)
      else $error("output stages not empty after reset");

   // The closing byte of a frame sits at the frame's last index.
   a_last_index: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tlast && rsp.frame_total > CountWidth'(2)
         |-> next_index == {1'b0, rsp.frame_total})
      else $error("frame closed at wrong index");

   // A header that declares two bytes or fewer closes the frame on its second byte.
   a_tiny_frame: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tlast && rsp.frame_total <= CountWidth'(2)
         |-> rsp.byte_index == CountWidth'(1))
      else $error("short frame closed at wrong index");

   // Bytes inside a frame of known size stay below its end.
   a_inside_frame: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tlast && rsp.frame_total != '0
         |-> next_index < {1'b0, rsp.frame_total})
      else $error("byte beyond frame end not marked last");

endmodule

bind stuffed_frame_receiver sfr_checker u_sfr_checker (.*);

`default_nettype wire
